// File: design/ksm_pkg.sv
// Package for the k-way sorted list merge: field widths, request codes,
// result status codes and the command record passed from front to back.
// No dependencies.
package ksm_pkg;

    // Fixed field widths of the request and result channels
    localparam int ACTION_W = 2;
    localparam int ID_W     = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 3;
    localparam int SRC_W    = 4;
    localparam int POS_W    = 9;
    localparam int CFG_W    = 4;

    // Lists in use after reset
    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

    // Request action codes
    localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_PULL   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_NONE   = 2'd3;

    // Command queue depth
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [STATUS_W-1:0] {
        ST_APPENDED  = 3'd0,
        ST_MERGED    = 3'd1,
        ST_FULL      = 3'd2,
        ST_EXHAUSTED = 3'd3,
        ST_CLEARED   = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        OP_APPEND,
        OP_PULL,
        OP_CLEAR
    } t_op;

    typedef struct packed {
        t_op                        op;
        logic                       id_bad;
        logic [ID_W-1:0]            list_id;
        logic signed [VALUE_W-1:0]  value;
    } t_cmd;

endpackage

// File: design/ksm_in_if.sv
// Request channel of the list merge: valid/ready plus the request fields.
// Depends on ksm_pkg.
interface ksm_in_if import ksm_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [ACTION_W-1:0]        action;
    logic [ID_W-1:0]            list_id;
    logic signed [VALUE_W-1:0]  sample_value;

    modport source (output valid, output action, output list_id, output sample_value,
                    input ready);
    modport sink   (input valid, input action, input list_id, input sample_value,
                    output ready);
endinterface

// File: design/ksm_out_if.sv
// Result channel of the list merge: valid/ready plus the result fields.
// Depends on ksm_pkg.
interface ksm_out_if import ksm_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [STATUS_W-1:0]        status;
    logic [SRC_W-1:0]           source_list;
    logic signed [VALUE_W-1:0]  merged_value;
    logic [POS_W-1:0]           position;
    logic                       last_item;

    modport source (output valid, output status, output source_list, output merged_value,
                    output position, output last_item, input ready);
    modport sink   (input valid, input status, input source_list, input merged_value,
                    input position, input last_item, output ready);
endinterface

// File: design/ksm_front.sv
// Front end: accepts requests, drops the unused action code and turns the
// rest into queue commands. Depends on ksm_pkg and ksm_in_if.
module ksm_front import ksm_pkg::*; #(
    parameter int NUM_LISTS = 8
) (
    ksm_in_if.sink  i_req,
    input  logic    i_full,
    output logic    o_push,
    output t_cmd    o_cmd
);

    // Take a request whenever the queue has room
    assign i_req.ready = !i_full;

    // Enqueue every accepted request except the unused code
    assign o_push = i_req.valid && !i_full && (i_req.action != ACT_NONE);

    // Classify the request
    always_comb begin
        o_cmd.list_id = i_req.list_id;
        o_cmd.value   = i_req.sample_value;
        o_cmd.id_bad  = (32'(i_req.list_id) >= NUM_LISTS);
        case (i_req.action)
            ACT_APPEND: o_cmd.op = OP_APPEND;
            ACT_PULL:   o_cmd.op = OP_PULL;
            ACT_CLEAR:  o_cmd.op = OP_CLEAR;
            default:    o_cmd.op = OP_CLEAR;
        endcase
    end

endmodule

// File: design/ksm_cmd_fifo.sv
// Short command queue between front and back end.
// Depends on ksm_pkg.
module ksm_cmd_fifo import ksm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cmd    i_cmd,
    output logic    o_full,
    input  logic    i_pop,
    output logic    o_empty,
    output t_cmd    o_cmd
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd               r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               w_push_ok;
    logic               w_pop_ok;

    assign o_full    = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_push_ok = i_push && !o_full;
    assign w_pop_ok  = i_pop && !o_empty;
    assign o_cmd     = r_slot[r_rd_ptr];

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push_ok) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (w_pop_ok) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            case ({w_push_ok, w_pop_ok})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    // Store the pushed command
    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// File: design/ksm_back.sv
// Back end: list memory, per-list fill and read counters, head scan for
// pulls and the result register. Depends on ksm_pkg and ksm_out_if.
module ksm_back import ksm_pkg::*; #(
    parameter int NUM_LISTS  = 8,
    parameter int LIST_DEPTH = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [CFG_W-1:0]    i_lists_in_use,
    input  logic                i_cmd_avail,
    input  t_cmd                i_cmd,
    output logic                o_pop,
    ksm_out_if.source           o_rsp
);

    localparam int LW        = $clog2(NUM_LISTS);
    localparam int PW        = $clog2(LIST_DEPTH);
    localparam int CW        = $clog2(LIST_DEPTH + 1);
    localparam int NW        = $clog2(NUM_LISTS + 1);
    localparam int AW        = LW + PW;
    localparam int MEM_WORDS = 1 << AW;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE,
        S_FINISH
    } t_state;

    t_state                     r_state;
    logic [CW-1:0]              r_fill [NUM_LISTS];
    logic [CW-1:0]              r_rd   [NUM_LISTS];
    logic signed [VALUE_W-1:0]  r_mem  [MEM_WORDS];
    logic signed [VALUE_W-1:0]  r_mem_q;
    logic                       r_q_valid;
    logic [LW-1:0]              r_q_list;
    logic [NW-1:0]              r_scan;
    logic                       r_found;
    logic [LW-1:0]              r_best;
    logic signed [VALUE_W-1:0]  r_best_val;
    logic [CW-1:0]              r_pos;

    logic                       r_out_valid;
    t_status                    r_out_status;
    logic [SRC_W-1:0]           r_out_src;
    logic signed [VALUE_W-1:0]  r_out_val;
    logic [POS_W-1:0]           r_out_pos;
    logic                       r_out_last;

    logic [NW-1:0]              w_active;
    logic [LW-1:0]              w_sel;
    logic [CW-1:0]              w_sel_fill;
    logic [CW-1:0]              w_sel_rd;
    logic                       w_full;
    logic                       w_slot_free;
    logic [NUM_LISTS-1:0]       w_live;
    logic                       w_more;
    logic                       w_rd_en;
    logic                       w_wr_en;
    logic                       w_take;
    logic                       w_rsp_load;

    // Clamp the number of lists in use to the lists built
    assign w_active = (32'(i_lists_in_use) > NUM_LISTS) ? NW'(NUM_LISTS)
                                                        : NW'(i_lists_in_use);

    assign w_slot_free = !r_out_valid || o_rsp.ready;

    // Pick the one list whose counters this cycle needs
    always_comb begin
        case (r_state)
            S_SCAN:   w_sel = LW'(r_scan);
            S_UPDATE: w_sel = r_best;
            default:  w_sel = LW'(i_cmd.list_id);
        endcase
    end

    assign w_sel_fill = r_fill[w_sel];
    assign w_sel_rd   = r_rd[w_sel];
    assign w_full     = i_cmd.id_bad || (w_sel_fill >= CW'(LIST_DEPTH));

    // Flag active lists that still hold unread elements
    always_comb begin
        for (int k = 0; k < NUM_LISTS; k++) begin
            w_live[k] = (NW'(k) < w_active) && (r_rd[k] != r_fill[k]);
        end
    end
    assign w_more = |w_live;

    // Take a command: pulls always, the others only with a free result slot
    assign o_pop = (r_state == S_IDLE) && i_cmd_avail
                && ((i_cmd.op == OP_PULL) || w_slot_free);

    // Load the result register for appends, clears and finished pulls
    assign w_rsp_load = (o_pop && (i_cmd.op != OP_PULL))
                     || ((r_state == S_FINISH) && w_slot_free);

    // Read one head per cycle during the scan, only from lists with data
    assign w_rd_en = (r_state == S_SCAN) && (r_scan < w_active) && (w_sel_rd != w_sel_fill);
    assign w_wr_en = o_pop && (i_cmd.op == OP_APPEND) && !w_full;

    // Keep the smaller head; on a tie the earlier list stays
    assign w_take = r_q_valid && (!r_found || (r_mem_q < r_best_val));

    // List memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[{w_sel, PW'(w_sel_fill)}] <= i_cmd.value;
        end
        if (w_rd_en) begin
            r_mem_q <= r_mem[{LW'(r_scan), PW'(w_sel_rd)}];
        end
    end

    // Sequencer, counters and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_q_valid   <= 1'b0;
            r_found     <= 1'b0;
            r_scan      <= '0;
            for (int k = 0; k < NUM_LISTS; k++) begin
                r_fill[k] <= '0;
                r_rd[k]   <= '0;
            end
        end else begin
            r_q_valid <= w_rd_en;
            r_q_list  <= LW'(r_scan);

            if (w_take) begin
                r_found    <= 1'b1;
                r_best     <= r_q_list;
                r_best_val <= r_mem_q;
            end

            // Raise valid for a new result, drop it once taken
            if (w_rsp_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        case (i_cmd.op)
                            OP_APPEND: begin
                                r_out_src   <= '0;
                                r_out_val   <= '0;
                                r_out_pos   <= '0;
                                r_out_last  <= 1'b0;
                                if (w_full) begin
                                    r_out_status <= ST_FULL;
                                end else begin
                                    r_out_status  <= ST_APPENDED;
                                    r_fill[w_sel] <= w_sel_fill + CW'(1);
                                end
                            end
                            OP_CLEAR: begin
                                for (int k = 0; k < NUM_LISTS; k++) begin
                                    r_fill[k] <= '0;
                                    r_rd[k]   <= '0;
                                end
                                r_out_status <= ST_CLEARED;
                                r_out_src    <= '0;
                                r_out_val    <= '0;
                                r_out_pos    <= '0;
                                r_out_last   <= 1'b0;
                            end
                            OP_PULL: begin
                                r_found <= 1'b0;
                                r_scan  <= '0;
                                r_state <= S_SCAN;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    // Issue head reads until every active list is covered
                    if (r_scan < w_active) begin
                        r_scan <= r_scan + NW'(1);
                    end else begin
                        r_state <= S_UPDATE;
                    end
                end
                S_UPDATE: begin
                    // Advance the read position of the winning list
                    if (r_found) begin
                        r_rd[r_best] <= w_sel_rd + CW'(1);
                        r_pos        <= w_sel_rd + CW'(1);
                    end
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    if (w_slot_free) begin
                        if (r_found) begin
                            r_out_status <= ST_MERGED;
                            r_out_src    <= SRC_W'(SRC_W'(r_best) + SRC_W'(1));
                            r_out_val    <= r_best_val;
                            r_out_pos    <= POS_W'(r_pos);
                            r_out_last   <= !w_more;
                        end else begin
                            r_out_status <= ST_EXHAUSTED;
                            r_out_src    <= '0;
                            r_out_val    <= '0;
                            r_out_pos    <= '0;
                            r_out_last   <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.source_list  = r_out_src;
    assign o_rsp.merged_value = r_out_val;
    assign o_rsp.position     = r_out_pos;
    assign o_rsp.last_item    = r_out_last;

endmodule

// File: design/kway_sorted_list_merge.sv
// K-way sorted list merge. Append and clear requests: result loaded when the back end takes
// the command, one per cycle while the result slot is free and no pull is in progress. Pull:
// scan, update and finish states in turn, with no new command taken until it ends; the scan
// reads one list head per cycle through the single list memory read port.
// Synchronous active-low reset empties all lists, the queue and the result register,
// and sets lists in use to 8. Depends on ksm_pkg, the interfaces and the submodules.
module kway_sorted_list_merge import ksm_pkg::*; #(
    parameter int NUM_LISTS  = 8,
    parameter int LIST_DEPTH = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CFG_W-1:0]    i_cfg_data,
    ksm_in_if.sink              i_req,
    ksm_out_if.source           o_rsp
);

    logic [CFG_W-1:0]   r_lists_cfg;
    logic               w_push;
    logic               w_full;
    logic               w_pop;
    logic               w_empty;
    t_cmd               w_cmd_in;
    t_cmd               w_cmd_out;

    // Hold the lists-in-use register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lists_cfg <= CFG_RESET;
        end else begin
            if (i_cfg_we) begin
                r_lists_cfg <= i_cfg_data;
            end
        end
    end

    ksm_front #(
        .NUM_LISTS (NUM_LISTS)
    ) u_front (
        .i_req  (i_req),
        .i_full (w_full),
        .o_push (w_push),
        .o_cmd  (w_cmd_in)
    );

    ksm_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_cmd   (w_cmd_out)
    );

    ksm_back #(
        .NUM_LISTS  (NUM_LISTS),
        .LIST_DEPTH (LIST_DEPTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_lists_in_use (r_lists_cfg),
        .i_cmd_avail    (!w_empty),
        .i_cmd          (w_cmd_out),
        .o_pop          (w_pop),
        .o_rsp          (o_rsp)
    );

`ifndef ASSERT_OFF
    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("request pushed into a full queue");

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("command popped from an empty queue");

    a_unused_code_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready && (i_req.action == ACT_NONE)) |-> !w_push)
        else $error("unused action code reached the queue");

    a_cfg_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (r_lists_cfg == $past(i_cfg_data)))
        else $error("lists-in-use write lost");
`endif

endmodule
